[design/rwpt_pkg.sv]
// Shared types and opcodes for the ranked weighted pick table.
package rwpt_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam int CAP_W = 9;

  typedef struct packed {
    logic [4:0]  rank;
    logic [2:0]  loot_type;
    logic [15:0] item_id;
    logic [6:0]  weight_percent;
  } rwpt_entry_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  rank;
    logic [2:0]  loot_type;
    logic [15:0] item_id;
    logic [6:0]  weight_percent;
    logic [6:0]  random_value;
  } rwpt_in_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  picked_type;
    logic [15:0] picked_item;
    logic        accepted;
  } rwpt_result_t;

endpackage

[design/ranked_weighted_pick_table.sv]
// Top level of the ranked weighted pick table: ports, capacity register, output register.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  in_      | in_tvalid/in_tready  | tuser opcode; tdata rank..random_value
//  out_     | out_tvalid/out_tready| tuser found, accepted; tdata type, item
//  cfg_     | cfg_valid/cfg_ready  | cfg_data table_capacity
//
// Clear, insert and unused opcodes go from accept straight to the output state.
// A sample first reads stored entries in order (at most the count) to form its result;
// the single table read port delivers one entry per cycle.
// Reset zeroes the entry count and capacity; the table itself is not cleared.
// One result waits in the output register while the next item is taken.
module ranked_weighted_pick_table #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_MATCHES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // rank[4:0], loot_type[7:5], item_id[23:8],
                                  // weight_percent[30:24], random_value[37:31], zero
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // picked_type[2:0], picked_item[18:3], zero
  output logic [1:0]  out_tuser,  // found[0], accepted[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // table_capacity[8:0]
);
  import rwpt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r;
  rwpt_result_t     out_res_r;

  rwpt_in_t     in_item;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  rwpt_entry_t  wr_data;
  logic         rd_en;
  logic [AW-1:0] rd_addr;
  rwpt_entry_t  rd_data;
  logic         res_valid;
  logic         res_ready;
  rwpt_result_t res;

  assign in_item = '{opcode: in_tuser, rank: in_tdata[4:0], loot_type: in_tdata[7:5],
                     item_id: in_tdata[23:8], weight_percent: in_tdata[30:24],
                     random_value: in_tdata[37:31]};

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_res_r.picked_item, out_res_r.picked_type};
  assign out_tuser  = {out_res_r.accepted, out_res_r.found};

  rwpt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MAX_MATCHES(MAX_MATCHES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .capacity (cap_r),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  rwpt_table_mem #(
    .DEPTH(TABLE_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

[design/rwpt_table_mem.sv]
// Outcome table storage: one write port, one registered read port.
module rwpt_table_mem #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  rwpt_pkg::rwpt_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output rwpt_pkg::rwpt_entry_t rd_data
);
  import rwpt_pkg::*;

  rwpt_entry_t mem_r [DEPTH];
  rwpt_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/rwpt_ctrl.sv]
// Opcode sequencer: insert, clear and the one-entry-per-cycle sample scan.
module rwpt_ctrl #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_MATCHES = 32,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rwpt_pkg::rwpt_in_t        in_item,
  input  logic [rwpt_pkg::CAP_W-1:0] capacity,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output rwpt_pkg::rwpt_entry_t     wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  rwpt_pkg::rwpt_entry_t     rd_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output rwpt_pkg::rwpt_result_t    res
);
  import rwpt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;
  localparam int MW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     addr_r, addr_nxt;
  logic [MW-1:0]     matches_r, matches_nxt;
  logic [4:0]        rank_r, rank_nxt;
  logic signed [7:0] value_r, value_nxt;
  rwpt_result_t      res_r, res_nxt;

  logic              accept;
  logic              room;
  logic              match;
  logic signed [7:0] diff;
  logic              hit;
  logic              limit;
  logic              stop;
  logic              more;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign room   = (XW'(count_r) < XW'(capacity)) && (count_r < CW'(TABLE_DEPTH));
  assign match  = (rd_data.rank == rank_r);
  assign diff   = value_r - $signed({1'b0, rd_data.weight_percent});
  assign hit    = match && diff[7];
  assign limit  = match && !diff[7] && (matches_r == MW'(MAX_MATCHES - 1));
  assign stop   = hit || limit;
  assign more   = (addr_r < count_r);

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_OUT);
  assign res       = res_r;

  assign wr_en   = accept && (in_item.opcode == OP_INSERT) && room;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = '{rank: in_item.rank, loot_type: in_item.loot_type,
                     item_id: in_item.item_id, weight_percent: in_item.weight_percent};

  assign rd_addr = (state_r == ST_IDLE) ? '0 : addr_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    addr_nxt    = addr_r;
    matches_nxt = matches_r;
    rank_nxt    = rank_r;
    value_nxt   = value_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt     = '0;
          rank_nxt    = in_item.rank;
          value_nxt   = $signed({1'b0, in_item.random_value});
          matches_nxt = '0;
          addr_nxt    = CW'(1);
          state_nxt   = ST_OUT;
          case (in_item.opcode)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_INSERT: begin
              if (room) begin
                count_nxt        = count_r + CW'(1);
                res_nxt.accepted = 1'b1;
              end
            end
            OP_SAMPLE: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        value_nxt = match ? diff : value_r;
        if (match) begin
          matches_nxt = matches_r + MW'(1);
        end
        if (stop || !more) begin
          state_nxt = ST_OUT;
          if (hit) begin
            res_nxt.found       = 1'b1;
            res_nxt.picked_type = rd_data.loot_type;
            res_nxt.picked_item = rd_data.item_id;
          end
        end else begin
          rd_en    = 1'b1;
          addr_nxt = addr_r + CW'(1);
        end
      end
      ST_OUT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    matches_r <= matches_nxt;
    rank_r    <= rank_nxt;
    value_r   <= value_nxt;
    res_r     <= res_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (addr_r <= count_r) && (addr_r != '0))
    else $error("scan address outside stored entries");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (count_r == $past(count_r) + CW'(1)) && res_r.accepted)
    else $error("stored insert did not advance count");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !wr_en && $stable(count_r))
    else $error("table modified during scan");

  a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> !(res_r.found && res_r.accepted))
    else $error("result both found and accepted");

endmodule
